>>> sv/ascii_sentence_xor_checker_defines.svh
// ------------------------------------------------------------------------
// Assertion macros for the ASCII sentence checker
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ------------------------------------------------------------------------
`ifndef ASCII_SENTENCE_XOR_CHECKER_DEFINES_SVH
`define ASCII_SENTENCE_XOR_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define ACX_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ACX_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/acx_pkg.sv
// ------------------------------------------------------------------------
// ACX package
// Character codes, status codes, result type and helper functions.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acx_pkg;

	// Character codes.
	localparam logic [7:0] CHR_DOLLAR = 8'h24;
	localparam logic [7:0] CHR_B      = 8'h42;
	localparam logic [7:0] CHR_D      = 8'h44;
	localparam logic [7:0] CHR_F      = 8'h46;
	localparam logic [7:0] CHR_P      = 8'h50;
	localparam logic [7:0] CHR_STAR   = 8'h2A;
	localparam logic [7:0] CHR_NL     = 8'h0A;
	localparam logic [7:0] CHR_NUL    = 8'h00;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_NINE   = 8'h39;
	localparam logic [7:0] CHR_A      = 8'h41;
	localparam logic [7:0] CHR_UF     = 8'h46;

	localparam logic [2:0] HDR_LEN      = 3'd6;
	localparam logic [7:0] LEN_CEILING  = 8'hFF;
	localparam logic [7:0] MAXLEN_RESET = 8'd199;

	// Result status codes.
	localparam logic [1:0] ST_VALID    = 2'd0;
	localparam logic [1:0] ST_BAD_HDR  = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;

	// Parse phase of the current sentence.
	typedef enum logic [1:0] {
		PH_SUM    = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	// One closed-sentence result.
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic [7:0] sentence_length;
		logic       truncated;
	} result_t;

	// Expected header character at a given position.
	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = CHR_DOLLAR;
			3'd1:    c = CHR_B;
			3'd2:    c = CHR_D;
			3'd3:    c = CHR_F;
			3'd4:    c = CHR_P;
			3'd5:    c = CHR_D;
			default: c = CHR_NUL;
		endcase
		return c;
	endfunction

	// Uppercase hex digit value; 16 marks a non-hex byte.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= CHR_ZERO && c <= CHR_NINE) begin
			v = {1'b0, 4'(c - CHR_ZERO)};
		end else if (c >= CHR_A && c <= CHR_UF) begin
			v = {1'b0, 4'(c - CHR_A + 8'd10)};
		end
		return v;
	endfunction

endpackage

`default_nettype wire

>>> sv/acx_in_stage.sv
// ------------------------------------------------------------------------
// ACX input stage
// Registers one incoming byte and releases it when the tracker advances.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acx_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// Room for a new byte when empty or when the held byte moves on.
	assign in_ready = !valid_s1 || advance;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

`default_nettype wire

>>> sv/acx_tracker.sv
// ------------------------------------------------------------------------
// ACX sentence tracker
// Per-byte header check, XOR sum, digit capture and sentence close.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_sentence_xor_checker_defines.svh"

module acx_tracker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      byte_s1,
	input  wire logic [7:0]      max_length,
	output logic                 close,
	output acx_pkg::result_t     result
);

	import acx_pkg::*;

	logic [7:0] byte_count_q;
	logic [2:0] header_index_q;
	logic       header_good_q;
	phase_t     phase_q;
	logic [7:0] running_xor_q;
	logic [7:0] high_digit_q;
	logic [7:0] low_digit_q;
	logic [1:0] digits_seen_q;

	logic [7:0] count_d;
	logic [2:0] index_d;
	logic       good_d;
	phase_t     phase_d;
	logic [7:0] xor_d;
	logic [7:0] high_d;
	logic [7:0] low_d;
	logic [1:0] seen_d;
	logic [7:0] limit;
	logic       is_nl;
	logic [4:0] hi_val;
	logic [4:0] lo_val;
	logic       digits_ok;
	logic [7:0] recv;

	assign is_nl = (byte_s1 == CHR_NL);
	assign limit = (max_length == 8'd0) ? 8'd1 : max_length;
	assign count_d = byte_count_q + 8'd1;

	// Header comparison over the first six bytes.
	always_comb begin
		index_d = header_index_q;
		good_d  = header_good_q;
		if (header_index_q < HDR_LEN) begin
			if (byte_s1 != hdr_char(header_index_q)) begin
				good_d = 1'b0;
			end
			index_d = header_index_q + 3'd1;
		end
	end

	// Summing and checksum digit capture; a newline changes nothing here.
	always_comb begin
		phase_d = phase_q;
		xor_d   = running_xor_q;
		high_d  = high_digit_q;
		low_d   = low_digit_q;
		seen_d  = digits_seen_q;
		if (!is_nl) begin
			unique case (phase_q)
				PH_SUM: begin
					if (byte_count_q != 8'd0) begin
						if (byte_s1 == CHR_STAR || byte_s1 == CHR_NUL) begin
							phase_d = PH_DIGITS;
						end else begin
							xor_d = running_xor_q ^ byte_s1;
						end
					end
				end
				PH_DIGITS: begin
					if (digits_seen_q == 2'd0) begin
						high_d = byte_s1;
						seen_d = 2'd1;
					end else begin
						low_d   = byte_s1;
						seen_d  = 2'd2;
						phase_d = PH_DONE;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Sentence close and result fields.
	assign close = is_nl || (count_d >= limit) || (count_d == LEN_CEILING);
	assign hi_val = hex_value(high_d);
	assign lo_val = hex_value(low_d);
	assign digits_ok = (seen_d == 2'd2) && !hi_val[4] && !lo_val[4];
	assign recv = digits_ok ? {hi_val[3:0], lo_val[3:0]} : 8'd0;

	always_comb begin
		result.computed_sum    = xor_d;
		result.received_sum    = recv;
		result.sentence_length = count_d;
		result.truncated       = !is_nl;
		if (!(good_d && index_d >= HDR_LEN)) begin
			result.status = ST_BAD_HDR;
		end else if (digits_ok && recv == xor_d) begin
			result.status = ST_VALID;
		end else begin
			result.status = ST_MISMATCH;
		end
	end

	// Sentence state; cleared after every closed sentence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= 8'd0;
			header_index_q <= 3'd0;
			header_good_q  <= 1'b1;
			phase_q        <= PH_SUM;
			running_xor_q  <= 8'd0;
			high_digit_q   <= 8'd0;
			low_digit_q    <= 8'd0;
			digits_seen_q  <= 2'd0;
		end else if (step) begin
			if (close) begin
				byte_count_q   <= 8'd0;
				header_index_q <= 3'd0;
				header_good_q  <= 1'b1;
				phase_q        <= PH_SUM;
				running_xor_q  <= 8'd0;
				high_digit_q   <= 8'd0;
				low_digit_q    <= 8'd0;
				digits_seen_q  <= 2'd0;
			end else begin
				byte_count_q   <= count_d;
				header_index_q <= index_d;
				header_good_q  <= good_d;
				phase_q        <= phase_d;
				running_xor_q  <= xor_d;
				high_digit_q   <= high_d;
				low_digit_q    <= low_d;
				digits_seen_q  <= seen_d;
			end
		end
	end

	`ACX_ASSERT_NXT(a_count_advances, step && !close, byte_count_q == $past(byte_count_q) + 8'd1, "byte count did not advance")
	`ACX_ASSERT_NXT(a_close_clears, step && close, byte_count_q == 8'd0 && header_index_q == 3'd0, "sentence state not cleared on close")
	`ACX_ASSERT_IMP(a_digits_phase, digits_seen_q == 2'd2, phase_q == PH_DONE, "two digits seen outside done phase")

endmodule

`default_nettype wire

>>> sv/acx_out_stage.sv
// ------------------------------------------------------------------------
// ACX output stage
// Result register that holds a closed-sentence result until transferred.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_sentence_xor_checker_defines.svh"

module acx_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire acx_pkg::result_t result,
	output logic                  free,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            status,
	output logic [7:0]            computed_sum,
	output logic [7:0]            received_sum,
	output logic [7:0]            sentence_length,
	output logic                  truncated
);

	import acx_pkg::*;

	logic    valid_s2;
	result_t result_s2;

	// The register can take a result when empty or when its content leaves.
	assign free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			result_s2 <= result;
		end
	end

	assign out_valid       = valid_s2;
	assign status          = result_s2.status;
	assign computed_sum    = result_s2.computed_sum;
	assign received_sum    = result_s2.received_sum;
	assign sentence_length = result_s2.sentence_length;
	assign truncated       = result_s2.truncated;

	`ACX_ASSERT_IMP(a_no_overwrite, load, free, "result loaded over an untaken result")

endmodule

`default_nettype wire

>>> sv/ascii_sentence_xor_checker.sv
// ------------------------------------------------------------------------
// ASCII sentence XOR checker
// Splits a byte stream into sentences, checks the header and the XOR
// checksum, and reports one result per closed sentence.
// ------------------------------------------------------------------------
//  Channel   Direction  Signals                       Moves
//  cfg       in         cfg_valid/ready, cfg_data     max_length write
//  in        in         in_valid/ready, data_byte     one stream byte
//  out       out        out_valid/ready, status ...   one sentence result
//
//  One byte per clock is sustained while no closing byte waits on a held
//  result. The input register takes a byte at its transfer; the tracker then
//  writes the result of a closing byte into the result register, which offers it.
//  Reset clears the sentence state and sets max_length to 199.
//  A stalled result only holds the input register when the waiting byte
//  closes a sentence; other bytes keep flowing.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ascii_sentence_xor_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic [7:0]      computed_sum,
	output logic [7:0]      received_sum,
	output logic [7:0]      sentence_length,
	output logic            truncated
);

	import acx_pkg::*;

	logic       load_result;
	logic [7:0] max_len_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       close;
	logic       out_free;
	result_t    result;

	// Configuration register; always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAXLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Byte moves through unless it closes a sentence while the result is held.
	assign advance = valid_s1 && (!close || out_free);
	assign load_result = advance && close;

	acx_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	acx_tracker u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.byte_s1    (byte_s1),
		.max_length (max_len_q),
		.close      (close),
		.result     (result)
	);

	acx_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load_result),
		.result          (result),
		.free            (out_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.computed_sum    (computed_sum),
		.received_sum    (received_sum),
		.sentence_length (sentence_length),
		.truncated       (truncated)
	);

endmodule

`default_nettype wire
